@@ design/tcd_pkg.sv @@
// Shared types, constants and tables for the tilt change detector.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int TABLE_LEN       = 24;
    localparam int IDX_W           = $clog2(TABLE_LEN);

    localparam int VW = 36;   // CORDIC x/y datapath
    localparam int AW = 26;   // internal angle, 1/65536 degree

    localparam int PW  = ANGLE_FRAC_BITS + 8;
    localparam int RW  = ANGLE_FRAC_BITS + 9;
    localparam int PCW = ANGLE_FRAC_BITS + 9;
    localparam int RCW = ANGLE_FRAC_BITS + 10;
    localparam int THR_W = 16;

    localparam int INV_GAIN_Q16 = 39797;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(20 << ANGLE_FRAC_BITS);

    localparam logic signed [AW-1:0] QUARTER_TURN = AW'(90 <<< 16);

    localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
        26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
        26'sd917, 26'sd458, 26'sd229, 26'sd115,
        26'sd57, 26'sd29, 26'sd14, 26'sd7,
        26'sd4, 26'sd2, 26'sd1, 26'sd0
    };

    typedef enum logic [1:0] {
        ST_ARMED   = 2'd0,
        ST_MEAS    = 2'd1,
        ST_RDFAULT = 2'd2,
        ST_LATCHED = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
        status_t              mode;
        logic signed [AW-1:0] aux;
    } vec_t;

endpackage

`default_nettype wire

@@ design/tcd_prep.sv @@
// Quadrant pre-rotation and zero-vector detect ahead of a CORDIC pass.
`timescale 1ns / 1ps
`default_nettype none

module tcd_prep (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  tcd_pkg::vec_t      in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tcd_pkg::vec_t      out_data
);
    import tcd_pkg::*;

    logic v_reg;
    vec_t d_reg;
    vec_t d_next;

    always_comb
    begin
        d_next      = in_data;
        d_next.zero = (in_data.x == '0) && (in_data.y == '0);
        d_next.ang  = '0;
        if (in_data.x < 0)
        begin
            if (in_data.y >= 0)
            begin
                d_next.x   = in_data.y;
                d_next.y   = -in_data.x;
                d_next.ang = QUARTER_TURN;
            end
            else
            begin
                d_next.x   = -in_data.y;
                d_next.y   = in_data.x;
                d_next.ang = -QUARTER_TURN;
            end
        end
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

@@ design/tcd_cell.sv @@
// One CORDIC vectoring iteration with its own pipeline register.
`timescale 1ns / 1ps
`default_nettype none

module tcd_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tcd_pkg::IDX_W-1:0] idx,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  tcd_pkg::vec_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output tcd_pkg::vec_t                  out_data
);
    import tcd_pkg::*;

    logic v_reg;
    vec_t d_reg;
    vec_t d_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    assign dx = in_data.y >>> idx;
    assign dy = in_data.x >>> idx;

    always_comb
    begin
        d_next = in_data;
        if (in_data.y >= 0)
        begin
            d_next.x   = in_data.x + dx;
            d_next.y   = in_data.y - dy;
            d_next.ang = in_data.ang + ATAN_TAB[idx];
        end
        else
        begin
            d_next.x   = in_data.x - dx;
            d_next.y   = in_data.y + dy;
            d_next.ang = in_data.ang - ATAN_TAB[idx];
        end
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

`default_nettype wire

@@ design/tcd_gain.sv @@
// Gain removal of the first-pass magnitude and setup of the pitch pass.
`timescale 1ns / 1ps
`default_nettype none

module tcd_gain (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  tcd_pkg::vec_t      in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output tcd_pkg::vec_t      out_data
);
    import tcd_pkg::*;

    localparam int MW = 33;
    localparam int LO = 16;

    logic        a_v_reg;
    logic [MW-LO+15:0] a_hi_reg;
    logic [LO+15:0]    a_lo_reg;
    logic signed [AW-1:0] a_ang_reg;
    logic signed [AW-1:0] a_aux_reg;
    status_t     a_mode_reg;
    logic        a_ready;

    logic        b_v_reg;
    vec_t        b_reg;
    vec_t        b_next;

    logic [MW-1:0]    mag;
    logic [MW+16:0]   sum;
    logic signed [VW-1:0] ax_ext;

    always_comb
    begin
        if (in_data.zero || in_data.x < 0)
            mag = '0;
        else
            mag = in_data.x[MW-1:0];
    end

    assign a_ready  = !b_v_reg || out_ready;
    assign in_ready = !a_v_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (in_ready)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_hi_reg   <= mag[MW-1:LO] * 16'(INV_GAIN_Q16);
            a_lo_reg   <= mag[LO-1:0] * 16'(INV_GAIN_Q16);
            a_ang_reg  <= in_data.zero ? '0 : in_data.ang;
            a_aux_reg  <= in_data.aux;
            a_mode_reg <= in_data.mode;
        end
    end

    assign sum = ({{(MW+17-(MW-LO+16)){1'b0}}, a_hi_reg} << LO)
               + {{(MW+17-(LO+16)){1'b0}}, a_lo_reg}
               + (MW+17)'(32768);
    assign ax_ext = VW'(signed'(a_aux_reg[15:0]));

    always_comb
    begin
        b_next      = '0;
        b_next.x    = VW'(sum[MW+16:16]);
        b_next.y    = (-ax_ext) <<< 16;
        b_next.mode = a_mode_reg;
        b_next.aux  = a_ang_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (a_ready)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_v_reg)
            b_reg <= b_next;
    end

    assign out_valid = b_v_reg;
    assign out_data  = b_reg;

endmodule

`default_nettype wire

@@ design/tcd_result.sv @@
// Angle rounding, reference hold, change and tilt compare, output register.
`timescale 1ns / 1ps
`default_nettype none

module tcd_result (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tcd_pkg::THR_W-1:0] threshold,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  tcd_pkg::vec_t                  in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     status,
    output logic signed [tcd_pkg::PW-1:0]  pitch_angle,
    output logic signed [tcd_pkg::RW-1:0]  roll_angle,
    output logic signed [tcd_pkg::PCW-1:0] pitch_change,
    output logic signed [tcd_pkg::RCW-1:0] roll_change,
    output logic                           tilted
);
    import tcd_pkg::*;

    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam int QW = AW + 1;

    function automatic logic signed [QW-1:0] quant(input logic signed [AW-1:0] a,
                                                   input logic signed [QW-1:0] lim);
        logic signed [QW-1:0] q;
        begin
            q = (QW'(a) + QW'(1 <<< (SH - 1))) >>> SH;
            if (q > lim)
                q = lim;
            if (q < -lim)
                q = -lim;
            return q;
        end
    endfunction

    logic                 a_v_reg;
    status_t              a_mode_reg;
    logic signed [PW-1:0] a_pitch_reg;
    logic signed [RW-1:0] a_roll_reg;
    logic                 a_ready;
    logic signed [QW-1:0] pq;
    logic signed [QW-1:0] rq;

    logic                  o_v_reg;
    status_t               o_st_reg;
    status_t               o_st_next;
    logic signed [PW-1:0]  o_p_reg;
    logic signed [PW-1:0]  o_p_next;
    logic signed [RW-1:0]  o_r_reg;
    logic signed [RW-1:0]  o_r_next;
    logic signed [PCW-1:0] o_dp_reg;
    logic signed [PCW-1:0] o_dp_next;
    logic signed [RCW-1:0] o_dr_reg;
    logic signed [RCW-1:0] o_dr_next;
    logic                  o_t_reg;
    logic                  o_t_next;

    logic signed [PW-1:0]  ref_p_reg;
    logic signed [RW-1:0]  ref_r_reg;
    logic signed [PCW-1:0] dp;
    logic signed [RCW-1:0] dr;
    logic [PCW-1:0]        adp;
    logic [RCW-1:0]        adr;

    assign pq = quant(in_data.zero ? '0 : in_data.ang, QW'(90 << ANGLE_FRAC_BITS));
    assign rq = quant(in_data.aux, QW'(180 << ANGLE_FRAC_BITS));

    assign a_ready  = !o_v_reg || !out_stall;
    assign in_ready = !a_v_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (in_ready)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_mode_reg  <= in_data.mode;
            a_pitch_reg <= pq[PW-1:0];
            a_roll_reg  <= rq[RW-1:0];
        end
    end

    assign dp  = PCW'(a_pitch_reg) - PCW'(ref_p_reg);
    assign dr  = RCW'(a_roll_reg) - RCW'(ref_r_reg);
    assign adp = dp[PCW-1] ? PCW'(-dp) : PCW'(dp);
    assign adr = dr[RCW-1] ? RCW'(-dr) : RCW'(dr);

    always_comb
    begin
        o_st_next = a_mode_reg;
        o_p_next  = '0;
        o_r_next  = '0;
        o_dp_next = '0;
        o_dr_next = '0;
        o_t_next  = 1'b0;
        case (a_mode_reg)
            ST_ARMED:
            begin
                o_p_next = a_pitch_reg;
                o_r_next = a_roll_reg;
            end
            ST_MEAS:
            begin
                o_p_next  = a_pitch_reg;
                o_r_next  = a_roll_reg;
                o_dp_next = dp;
                o_dr_next = dr;
                o_t_next  = (RCW'(adp) > RCW'(threshold)) || (adr > RCW'(threshold));
            end
            default:
            begin
                o_st_next = a_mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg   <= 1'b0;
            ref_p_reg <= '0;
            ref_r_reg <= '0;
        end
        else
        begin
            if (a_ready)
                o_v_reg <= a_v_reg;
            if (a_ready && a_v_reg && a_mode_reg == ST_ARMED)
            begin
                ref_p_reg <= a_pitch_reg;
                ref_r_reg <= a_roll_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_v_reg)
        begin
            o_st_reg <= o_st_next;
            o_p_reg  <= o_p_next;
            o_r_reg  <= o_r_next;
            o_dp_reg <= o_dp_next;
            o_dr_reg <= o_dr_next;
            o_t_reg  <= o_t_next;
        end
    end

    assign out_valid    = o_v_reg;
    assign status       = o_st_reg;
    assign pitch_angle  = o_p_reg;
    assign roll_angle   = o_r_reg;
    assign pitch_change = o_dp_reg;
    assign roll_change  = o_dr_reg;
    assign tilted       = o_t_reg;

endmodule

`default_nettype wire

@@ design/tilt_change_detector.sv @@
// Top level of the tilt change detector: arming control and the two CORDIC cell chains.
//
//   channel   direction  handshake          payload
//   in        sink       in_valid/in_stall  accel_x, accel_y, accel_z, read_ok
//   out       source     out_valid/out_stall status, angles, changes, tilted
//   cfg       sink       cfg_valid/cfg_ready cfg_data (tilt threshold)
//
// One item per cycle while out_stall is low; the path runs through the two
// chains of CORDIC iteration cells, the gain multiply and the output stages.
// Reset empties every stage, disarms the block and loads a 20 degree threshold.
// A stall only holds stages that are full; empty stages still take items.
`timescale 1ns / 1ps
`default_nettype none

module tilt_change_detector (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [15:0]                accel_x,
    input  wire logic signed [15:0]                accel_y,
    input  wire logic signed [15:0]                accel_z,
    input  wire logic                              read_ok,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic signed [tcd_pkg::PW-1:0]          pitch_angle,
    output logic signed [tcd_pkg::RW-1:0]          roll_angle,
    output logic signed [tcd_pkg::PCW-1:0]         pitch_change,
    output logic signed [tcd_pkg::RCW-1:0]         roll_change,
    output logic                                   tilted,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tcd_pkg::THR_W-1:0]         cfg_data
);
    import tcd_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT  = 3'b001,
        PH_ARMED = 3'b010,
        PH_FAULT = 3'b100
    } phase_t;

    phase_t  phase_reg;
    phase_t  phase_next;
    status_t mode;
    logic [THR_W-1:0] thr_reg;

    logic accept;
    logic p1_ready;
    vec_t p1_in;

    logic c1_v     [CORDIC_STAGES+1];
    logic c1_r     [CORDIC_STAGES+1];
    vec_t c1_d     [CORDIC_STAGES+1];
    logic c2_v     [CORDIC_STAGES+1];
    logic c2_r     [CORDIC_STAGES+1];
    vec_t c2_d     [CORDIC_STAGES+1];

    logic g_v;
    logic g_r;
    vec_t g_d;
    logic res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid && cfg_ready)
            thr_reg <= cfg_data;
    end

    assign accept   = in_valid && p1_ready;
    assign in_stall = !p1_ready;

    always_comb
    begin
        phase_next = phase_reg;
        mode       = ST_LATCHED;
        case (phase_reg)
            PH_WAIT:
            begin
                if (read_ok)
                begin
                    phase_next = PH_ARMED;
                    mode       = ST_ARMED;
                end
                else
                begin
                    phase_next = PH_FAULT;
                    mode       = ST_LATCHED;
                end
            end
            PH_ARMED:
            begin
                mode = read_ok ? ST_MEAS : ST_RDFAULT;
            end
            default:
            begin
                mode = ST_LATCHED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_WAIT;
        else if (accept)
            phase_reg <= phase_next;
    end

    always_comb
    begin
        p1_in      = '0;
        p1_in.x    = VW'(signed'(accel_z)) <<< 16;
        p1_in.y    = VW'(signed'(accel_y)) <<< 16;
        p1_in.mode = mode;
        p1_in.aux  = AW'(signed'(accel_x));
    end

    tcd_prep u_prep1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (p1_ready),
        .in_data   (p1_in),
        .out_valid (c1_v[0]),
        .out_ready (c1_r[0]),
        .out_data  (c1_d[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_roll
        tcd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(i)),
            .in_valid  (c1_v[i]),
            .in_ready  (c1_r[i]),
            .in_data   (c1_d[i]),
            .out_valid (c1_v[i+1]),
            .out_ready (c1_r[i+1]),
            .out_data  (c1_d[i+1])
        );
    end

    tcd_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_v[CORDIC_STAGES]),
        .in_ready  (c1_r[CORDIC_STAGES]),
        .in_data   (c1_d[CORDIC_STAGES]),
        .out_valid (g_v),
        .out_ready (g_r),
        .out_data  (g_d)
    );

    tcd_prep u_prep2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_v),
        .in_ready  (g_r),
        .in_data   (g_d),
        .out_valid (c2_v[0]),
        .out_ready (c2_r[0]),
        .out_data  (c2_d[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_pitch
        tcd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(i)),
            .in_valid  (c2_v[i]),
            .in_ready  (c2_r[i]),
            .in_data   (c2_d[i]),
            .out_valid (c2_v[i+1]),
            .out_ready (c2_r[i+1]),
            .out_data  (c2_d[i+1])
        );
    end

    assign c2_r[CORDIC_STAGES] = res_ready;

    tcd_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold    (thr_reg),
        .in_valid     (c2_v[CORDIC_STAGES]),
        .in_ready     (res_ready),
        .in_data      (c2_d[CORDIC_STAGES]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .pitch_change (pitch_change),
        .roll_change  (roll_change),
        .tilted       (tilted)
    );

endmodule

`default_nettype wire
